// ----- rtl/physical_page_free_stack_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef PHYSICAL_PAGE_FREE_STACK_ALLOCATOR_DEFINES_SVH
`define PHYSICAL_PAGE_FREE_STACK_ALLOCATOR_DEFINES_SVH

// Overlapping implication on the rising edge of clk, off during reset.
`define PPFSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PPFSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppfsa_pkg.sv -----
package ppfsa_pkg;

  localparam int FUNC_W      = 3;
  localparam int IN_FRAME_W  = 40;
  localparam int OUT_FRAME_W = 40;
  localparam int STATUS_W    = 2;
  localparam int FREE_W      = 21;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC_SMALL       = 3'd0,
    FUNC_ALLOC_SMALL_CLEAN = 3'd1,
    FUNC_ALLOC_LARGE       = 3'd2,
    FUNC_ALLOC_LARGE_CLEAN = 3'd3,
    FUNC_FREE_SMALL        = 3'd4,
    FUNC_FREE_LARGE        = 3'd5,
    FUNC_FREE_SMALL_CLEAN  = 3'd6,
    FUNC_FREE_LARGE_CLEAN  = 3'd7
  } func_t;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    POOL_SMALL_DIRTY = 2'd0,
    POOL_SMALL_CLEAN = 2'd1,
    POOL_LARGE_DIRTY = 2'd2,
    POOL_LARGE_CLEAN = 2'd3
  } pool_id_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CARVE = 2'd2,
    ACT_PUSH  = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

// ----- rtl/physical_page_free_stack_allocator.sv -----
// Page frame allocator with four LIFO free pools (small dirty, small clean, large dirty,
// large clean) held in one synchronous stack memory, plus a carve region per small pool
// that hands out the rest of a split large page in descending frames. An item is taken
// when start is high and busy is low. Frees, carved allocations and out-of-memory
// answers give their result item in the cycle after acceptance and leave busy low, so
// such items can be issued every cycle. An allocation that pops a stack holds busy high
// for the cycle after acceptance, while the synchronous stack memory fetches the frame,
// and the result item follows in the cycle after that, when busy is low again and the
// next item can be taken. Each result item is on the out_ ports for exactly one cycle,
// marked by out_strobe; the receiver cannot hold it off, so it must take every strobe.
// The stacks need no clearing after reset: only entries below a pool's top are ever read.
module physical_page_free_stack_allocator #(
  parameter int STACK_DEPTH     = 1024,
  parameter int SMALL_PER_LARGE = 512,
  parameter int FRAME_BITS      = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ppfsa_pkg::FUNC_W-1:0]        in_func,
  input  logic [ppfsa_pkg::IN_FRAME_W-1:0]    in_page_frame,
  output logic                                out_strobe,
  output logic [ppfsa_pkg::OUT_FRAME_W-1:0]   out_alloc_frame,
  output logic                                out_alloc_valid,
  output logic                                out_needs_clear,
  output logic [ppfsa_pkg::STATUS_W-1:0]      out_status,
  output logic [ppfsa_pkg::FREE_W-1:0]        out_free_pages
);
  import ppfsa_pkg::*;
  `include "physical_page_free_stack_allocator_defines.svh"

  localparam int TOP_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int LEFT_W = $clog2(SMALL_PER_LARGE);
  localparam int WIDE_W = (FRAME_BITS > IN_FRAME_W) ? FRAME_BITS : IN_FRAME_W;

  localparam logic [TOP_W-1:0]  TOP_FULL  = TOP_W'(STACK_DEPTH);
  localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(SMALL_PER_LARGE - 1);

  // Pool occupancy and carve regions.
  logic [TOP_W-1:0]      sd_top_r, sd_top_nxt, sc_top_r, sc_top_nxt;
  logic [TOP_W-1:0]      ld_top_r, ld_top_nxt, lc_top_r, lc_top_nxt;
  logic [FRAME_BITS-1:0] dbase_r, dbase_nxt, cbase_r, cbase_nxt;
  logic [LEFT_W-1:0]     dleft_r, dleft_nxt, cleft_r, cleft_nxt;

  state_t state_r, state_nxt;

  // Details of an outstanding pop, kept for the read cycle.
  logic pend_clear_r, pend_clear_nxt;
  logic pend_split_r, pend_split_nxt;
  logic pend_split_clean_r, pend_split_clean_nxt;

  // Result registers.
  logic                   strobe_r, strobe_nxt;
  logic [FRAME_BITS-1:0]  frame_r, frame_nxt;
  logic                   valid_r, valid_nxt;
  logic                   clear_r, clear_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;

  // Stack memory, one bank of STACK_DEPTH entries for each pool.
  logic [FRAME_BITS-1:0] stack_mem [4][STACK_DEPTH];
  logic [FRAME_BITS-1:0] rd_data_r;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_idx;

  // Decision for the item at the input.
  action_t               act;
  pool_id_t              pool;
  logic                  carve_clean;
  logic                  split;
  logic                  clear;
  logic                  accept;
  logic                  full;
  logic [TOP_W-1:0]      sel_top;
  logic [TOP_W-1:0]      sel_top_dec;
  logic [FRAME_BITS-1:0] carve_frame;
  logic [FRAME_BITS-1:0] page_frame;
  logic [WIDE_W-1:0]     pf_wide;
  logic [WIDE_W-1:0]     frame_wide;
  logic                  sd_av, sc_av, ld_av, lc_av, dc_av, cc_av;
  logic [TOP_W:0]        large_sum;
  logic [FREE_W-1:0]     large_pages;

  assign busy   = (state_r == ST_READ);
  assign accept = start && !busy;

  assign pf_wide    = WIDE_W'(in_page_frame);
  assign page_frame = pf_wide[FRAME_BITS-1:0];

  assign sd_av = (sd_top_r != '0);
  assign sc_av = (sc_top_r != '0);
  assign ld_av = (ld_top_r != '0);
  assign lc_av = (lc_top_r != '0);
  assign dc_av = (dleft_r != '0);
  assign cc_av = (cleft_r != '0);

  // Pool search order for each request. Splitting a large page only happens once both
  // small pools and both carve regions are empty.
  always_comb begin
    act         = ACT_NONE;
    pool        = POOL_SMALL_DIRTY;
    carve_clean = 1'b0;
    split       = 1'b0;
    clear       = 1'b0;
    case (func_t'(in_func))
      FUNC_ALLOC_SMALL: begin
        if (sd_av) begin
          act = ACT_POP;  pool = POOL_SMALL_DIRTY;
        end else if (dc_av) begin
          act = ACT_CARVE;
        end else if (sc_av) begin
          act = ACT_POP;  pool = POOL_SMALL_CLEAN;
        end else if (cc_av) begin
          act = ACT_CARVE; carve_clean = 1'b1;
        end else if (ld_av) begin
          act = ACT_POP;  pool = POOL_LARGE_DIRTY; split = 1'b1;
        end else if (lc_av) begin
          act = ACT_POP;  pool = POOL_LARGE_CLEAN; split = 1'b1; carve_clean = 1'b1;
        end
      end
      FUNC_ALLOC_SMALL_CLEAN: begin
        if (sc_av) begin
          act = ACT_POP;  pool = POOL_SMALL_CLEAN;
        end else if (cc_av) begin
          act = ACT_CARVE; carve_clean = 1'b1;
        end else if (sd_av) begin
          act = ACT_POP;  pool = POOL_SMALL_DIRTY; clear = 1'b1;
        end else if (dc_av) begin
          act = ACT_CARVE; clear = 1'b1;
        end else if (lc_av) begin
          act = ACT_POP;  pool = POOL_LARGE_CLEAN; split = 1'b1; carve_clean = 1'b1;
        end else if (ld_av) begin
          act = ACT_POP;  pool = POOL_LARGE_DIRTY; split = 1'b1; clear = 1'b1;
        end
      end
      FUNC_ALLOC_LARGE: begin
        if (ld_av) begin
          act = ACT_POP;  pool = POOL_LARGE_DIRTY;
        end else if (lc_av) begin
          act = ACT_POP;  pool = POOL_LARGE_CLEAN;
        end
      end
      FUNC_ALLOC_LARGE_CLEAN: begin
        if (lc_av) begin
          act = ACT_POP;  pool = POOL_LARGE_CLEAN;
        end else if (ld_av) begin
          act = ACT_POP;  pool = POOL_LARGE_DIRTY; clear = 1'b1;
        end
      end
      FUNC_FREE_SMALL: begin
        act = ACT_PUSH; pool = POOL_SMALL_DIRTY;
      end
      FUNC_FREE_LARGE: begin
        act = ACT_PUSH; pool = POOL_LARGE_DIRTY;
      end
      FUNC_FREE_SMALL_CLEAN: begin
        act = ACT_PUSH; pool = POOL_SMALL_CLEAN;
      end
      FUNC_FREE_LARGE_CLEAN: begin
        act = ACT_PUSH; pool = POOL_LARGE_CLEAN;
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    case (pool)
      POOL_SMALL_DIRTY: sel_top = sd_top_r;
      POOL_SMALL_CLEAN: sel_top = sc_top_r;
      POOL_LARGE_DIRTY: sel_top = ld_top_r;
      POOL_LARGE_CLEAN: sel_top = lc_top_r;
      default:          sel_top = sd_top_r;
    endcase
  end

  assign sel_top_dec = sel_top - TOP_W'(1);
  assign full        = (sel_top >= TOP_FULL);
  assign carve_frame = carve_clean ? (cbase_r + FRAME_BITS'(cleft_r))
                                   : (dbase_r + FRAME_BITS'(dleft_r));

  // A push writes at the top, a pop reads just below it. One access per item, and the
  // read of a pop always comes in a later cycle than any earlier write.
  assign mem_we  = accept && (act == ACT_PUSH) && !full;
  assign mem_re  = accept && (act == ACT_POP);
  assign mem_idx = (act == ACT_POP) ? sel_top_dec[IDX_W-1:0] : sel_top[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[pool][mem_idx] <= page_frame;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[pool][mem_idx];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (act == ACT_POP)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Pool state updates and result formation.
  always_comb begin
    sd_top_nxt           = sd_top_r;
    sc_top_nxt           = sc_top_r;
    ld_top_nxt           = ld_top_r;
    lc_top_nxt           = lc_top_r;
    dbase_nxt            = dbase_r;
    cbase_nxt            = cbase_r;
    dleft_nxt            = dleft_r;
    cleft_nxt            = cleft_r;
    pend_clear_nxt       = pend_clear_r;
    pend_split_nxt       = pend_split_r;
    pend_split_clean_nxt = pend_split_clean_r;
    strobe_nxt           = 1'b0;
    frame_nxt            = '0;
    valid_nxt            = 1'b0;
    clear_nxt            = 1'b0;
    status_nxt           = STATUS_OK;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_POP: begin
              case (pool)
                POOL_SMALL_DIRTY: sd_top_nxt = sel_top_dec;
                POOL_SMALL_CLEAN: sc_top_nxt = sel_top_dec;
                POOL_LARGE_DIRTY: ld_top_nxt = sel_top_dec;
                POOL_LARGE_CLEAN: lc_top_nxt = sel_top_dec;
                default:          sd_top_nxt = sel_top_dec;
              endcase
              if (split) begin
                if (carve_clean) begin
                  cleft_nxt = LEFT_INIT;
                end else begin
                  dleft_nxt = LEFT_INIT;
                end
              end
              pend_clear_nxt       = clear;
              pend_split_nxt       = split;
              pend_split_clean_nxt = carve_clean;
            end
            ACT_CARVE: begin
              if (carve_clean) begin
                cleft_nxt = cleft_r - LEFT_W'(1);
              end else begin
                dleft_nxt = dleft_r - LEFT_W'(1);
              end
              strobe_nxt = 1'b1;
              frame_nxt  = carve_frame;
              valid_nxt  = 1'b1;
              clear_nxt  = clear;
            end
            ACT_PUSH: begin
              if (full) begin
                status_nxt = STATUS_FULL;
              end else begin
                case (pool)
                  POOL_SMALL_DIRTY: sd_top_nxt = sel_top + TOP_W'(1);
                  POOL_SMALL_CLEAN: sc_top_nxt = sel_top + TOP_W'(1);
                  POOL_LARGE_DIRTY: ld_top_nxt = sel_top + TOP_W'(1);
                  POOL_LARGE_CLEAN: lc_top_nxt = sel_top + TOP_W'(1);
                  default:          sd_top_nxt = sel_top + TOP_W'(1);
                endcase
              end
              strobe_nxt = 1'b1;
            end
            ACT_NONE: begin
              strobe_nxt = 1'b1;
              status_nxt = STATUS_OOM;
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = STATUS_OOM;
            end
          endcase
        end
      end
      ST_READ: begin
        // The popped frame is the answer; a split also makes it the carve base.
        if (pend_split_r) begin
          if (pend_split_clean_r) begin
            cbase_nxt = rd_data_r;
          end else begin
            dbase_nxt = rd_data_r;
          end
        end
        strobe_nxt = 1'b1;
        frame_nxt  = rd_data_r;
        valid_nxt  = 1'b1;
        clear_nxt  = pend_clear_r;
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sd_top_r <= '0;
      sc_top_r <= '0;
      ld_top_r <= '0;
      lc_top_r <= '0;
      dbase_r  <= '0;
      cbase_r  <= '0;
      dleft_r  <= '0;
      cleft_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sd_top_r <= sd_top_nxt;
      sc_top_r <= sc_top_nxt;
      ld_top_r <= ld_top_nxt;
      lc_top_r <= lc_top_nxt;
      dbase_r  <= dbase_nxt;
      cbase_r  <= cbase_nxt;
      dleft_r  <= dleft_nxt;
      cleft_r  <= cleft_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_clear_r       <= pend_clear_nxt;
    pend_split_r       <= pend_split_nxt;
    pend_split_clean_r <= pend_split_clean_nxt;
    frame_r            <= frame_nxt;
    valid_r            <= valid_nxt;
    clear_r            <= clear_nxt;
    status_r           <= status_nxt;
  end

  // The free count is taken from the pool state during the result cycle, when it
  // already holds this item's update and not yet that of any following item.
  assign large_sum   = (TOP_W + 1)'(ld_top_r) + (TOP_W + 1)'(lc_top_r);
  assign large_pages = FREE_W'(large_sum) * FREE_W'(SMALL_PER_LARGE);

  assign frame_wide      = WIDE_W'(frame_r);
  assign out_strobe      = strobe_r;
  assign out_alloc_frame = frame_wide[OUT_FRAME_W-1:0];
  assign out_alloc_valid = valid_r;
  assign out_needs_clear = clear_r;
  assign out_status      = status_r;
  assign out_free_pages  = FREE_W'(sd_top_r) + FREE_W'(sc_top_r) + FREE_W'(dleft_r)
                         + FREE_W'(cleft_r) + large_pages;

  `PPFSA_ASSERT_NOW(a_no_result_in_read, state_r == ST_READ, !out_strobe,
                    "result item shown while a stack read is outstanding")
  `PPFSA_ASSERT_NEXT(a_item_answered, accept, out_strobe || state_r == ST_READ,
                     "accepted item neither answered nor waiting on the stack")
  `PPFSA_ASSERT_NEXT(a_read_completes, state_r == ST_READ,
                     out_strobe && out_alloc_valid && state_r == ST_IDLE,
                     "stack read did not deliver an allocated frame")
  `PPFSA_ASSERT_NOW(a_tops_bounded, 1'b1,
                    sd_top_r <= TOP_FULL && sc_top_r <= TOP_FULL &&
                    ld_top_r <= TOP_FULL && lc_top_r <= TOP_FULL,
                    "pool occupancy beyond the stack depth")
  `PPFSA_ASSERT_NOW(a_valid_means_ok, out_strobe && out_alloc_valid,
                    out_status == STATUS_OK,
                    "allocated frame reported with an error status")

endmodule

// ----- dv/page_pool_scoreboard_pkg.sv -----
`timescale 1ns / 1ps

package page_pool_scoreboard_pkg;

  import ppfsa_pkg::*;

  localparam int POOL_DEPTH      = 1024;
  localparam int SMALL_PER_LARGE = 512;

  typedef logic [OUT_FRAME_W-1:0] frame_t;

  typedef struct packed {
    frame_t              frame;
    logic                valid;
    logic                clear;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_pages;
  } alloc_result_t;

  // Keeps its own copy of the four pools and both carve regions, works out the
  // result of every accepted item and checks the block's results in order.
  class page_pool_scoreboard;

    frame_t        pool_mem [4][POOL_DEPTH];
    int unsigned   pool_top [4];
    frame_t        carve_base [2];
    int unsigned   carve_left [2];
    alloc_result_t expected_results [$];

    int unsigned error_count;
    int unsigned item_count;
    int unsigned oom_count;
    int unsigned full_count;
    int unsigned split_count;
    int unsigned clear_count;

    function new();
      foreach (pool_top[i]) pool_top[i] = 0;
      foreach (carve_left[i]) begin
        carve_left[i] = 0;
        carve_base[i] = '0;
      end
      error_count = 0;
      item_count  = 0;
      oom_count   = 0;
      full_count  = 0;
      split_count = 0;
      clear_count = 0;
    endfunction

    function bit pop_pool(pool_id_t p, output frame_t f);
      f = '0;
      if (pool_top[p] == 0) return 1'b0;
      pool_top[p]--;
      f = pool_mem[p][pool_top[p]];
      return 1'b1;
    endfunction

    function bit push_pool(pool_id_t p, frame_t f);
      if (pool_top[p] >= POOL_DEPTH) return 1'b0;
      pool_mem[p][pool_top[p]] = f;
      pool_top[p]++;
      return 1'b1;
    endfunction

    // A small pool serves from its stack first, then from its carve region,
    // which counts down from the top of the split large page.
    function bit take_small(pool_id_t p, output frame_t f);
      if (pop_pool(p, f)) return 1'b1;
      if (carve_left[p] == 0) return 1'b0;
      f = carve_base[p] + frame_t'(carve_left[p]);
      carve_left[p]--;
      return 1'b1;
    endfunction

    function bit split_large(pool_id_t large_p, pool_id_t small_p, output frame_t f);
      if (!pop_pool(large_p, f)) return 1'b0;
      carve_base[small_p] = f;
      carve_left[small_p] = SMALL_PER_LARGE - 1;
      split_count++;
      return 1'b1;
    endfunction

    function void note_item(func_t fn, frame_t pf);
      alloc_result_t       r;
      frame_t              f;
      bit                  got;
      bit                  clr;
      logic [STATUS_W-1:0] st;
      int unsigned         total;
      got = 1'b0;
      clr = 1'b0;
      st  = STATUS_OK;
      f   = '0;
      case (fn)
        FUNC_ALLOC_SMALL: begin
          got = take_small(POOL_SMALL_DIRTY, f);
          if (!got) got = take_small(POOL_SMALL_CLEAN, f);
          if (!got) got = split_large(POOL_LARGE_DIRTY, POOL_SMALL_DIRTY, f);
          if (!got) got = split_large(POOL_LARGE_CLEAN, POOL_SMALL_CLEAN, f);
        end
        FUNC_ALLOC_SMALL_CLEAN: begin
          got = take_small(POOL_SMALL_CLEAN, f);
          if (!got) begin
            got = take_small(POOL_SMALL_DIRTY, f);
            clr = got;
          end
          if (!got) got = split_large(POOL_LARGE_CLEAN, POOL_SMALL_CLEAN, f);
          if (!got) begin
            got = split_large(POOL_LARGE_DIRTY, POOL_SMALL_DIRTY, f);
            clr = got;
          end
        end
        FUNC_ALLOC_LARGE: begin
          got = pop_pool(POOL_LARGE_DIRTY, f);
          if (!got) got = pop_pool(POOL_LARGE_CLEAN, f);
        end
        FUNC_ALLOC_LARGE_CLEAN: begin
          got = pop_pool(POOL_LARGE_CLEAN, f);
          if (!got) begin
            got = pop_pool(POOL_LARGE_DIRTY, f);
            clr = got;
          end
        end
        FUNC_FREE_SMALL:       if (!push_pool(POOL_SMALL_DIRTY, pf)) st = STATUS_FULL;
        FUNC_FREE_LARGE:       if (!push_pool(POOL_LARGE_DIRTY, pf)) st = STATUS_FULL;
        FUNC_FREE_SMALL_CLEAN: if (!push_pool(POOL_SMALL_CLEAN, pf)) st = STATUS_FULL;
        default:               if (!push_pool(POOL_LARGE_CLEAN, pf)) st = STATUS_FULL;
      endcase
      if (fn < FUNC_FREE_SMALL && !got) begin
        st  = STATUS_OOM;
        clr = 1'b0;
      end
      total = pool_top[POOL_SMALL_DIRTY] + pool_top[POOL_SMALL_CLEAN]
            + carve_left[POOL_SMALL_DIRTY] + carve_left[POOL_SMALL_CLEAN]
            + (pool_top[POOL_LARGE_DIRTY] + pool_top[POOL_LARGE_CLEAN]) * SMALL_PER_LARGE;
      r.frame      = got ? f : '0;
      r.valid      = got;
      r.clear      = clr;
      r.status     = st;
      r.free_pages = FREE_W'(total);
      expected_results.push_back(r);
      item_count++;
      if (st == STATUS_OOM)  oom_count++;
      if (st == STATUS_FULL) full_count++;
      if (clr)               clear_count++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("[%0t] %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(frame_t frame, logic valid, logic clear,
                               logic [STATUS_W-1:0] status, logic [FREE_W-1:0] free_pages);
      alloc_result_t want;
      if (expected_results.size() == 0) begin
        $display("[%0t] result with no item waiting: frame 0x%0h, status %0d",
                 $time, frame, status);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("out_alloc_frame", 64'(want.frame), 64'(frame));
      compare_field("out_alloc_valid", 64'(want.valid), 64'(valid));
      compare_field("out_needs_clear", 64'(want.clear), 64'(clear));
      compare_field("out_status", 64'(want.status), 64'(status));
      compare_field("out_free_pages", 64'(want.free_pages), 64'(free_pages));
    endfunction

  endclass

endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// Top level of the allocator testbench. A directed opening walks through the
// fallback orders, splitting, carving across the top of the frame space, the
// clear flag and out-of-memory answers; a random part then mixes free bursts,
// allocation drains and one fill of a pool past its capacity. Every accepted
// item is handed to the scoreboard, which predicts its result, and every strobed
// result is checked against the oldest prediction.
module testbench;

  import ppfsa_pkg::*;
  import page_pool_scoreboard_pkg::*;

  // Directed and random items together; no new episode starts once this is reached.
  localparam int TOTAL_ITEMS = 1725;
  localparam int DRAIN_LIMIT = 2000;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   start         = 1'b0;
  logic [FUNC_W-1:0]      in_func       = '0;
  logic [IN_FRAME_W-1:0]  in_page_frame = '0;
  logic                   busy;
  logic                   out_strobe;
  logic [OUT_FRAME_W-1:0] out_alloc_frame;
  logic                   out_alloc_valid;
  logic                   out_needs_clear;
  logic [STATUS_W-1:0]    out_status;
  logic [FREE_W-1:0]      out_free_pages;

  page_pool_scoreboard sb;

  // When set, the sender issues items back to back with no idle cycles.
  bit quiet_sender;

  physical_page_free_stack_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_page_frame   (in_page_frame),
    .out_strobe      (out_strobe),
    .out_alloc_frame (out_alloc_frame),
    .out_alloc_valid (out_alloc_valid),
    .out_needs_clear (out_needs_clear),
    .out_status      (out_status),
    .out_free_pages  (out_free_pages)
  );

  always #4 clk = ~clk;

  // Outputs are read in the active region of the rising edge, so they still hold
  // the values of the cycle that this edge closes. The receiver cannot stall, so
  // every strobe is a result that must be checked.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result(out_alloc_frame, out_alloc_valid, out_needs_clear,
                      out_status, out_free_pages);
    end
  end

  // Presents one item and returns at the edge that accepts it. When the next item
  // follows with no gap, start simply stays high and only the payload changes, so
  // start never sees two assignments within one time step.
  task automatic send_item(func_t fn, frame_t pf);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= fn;
    in_page_frame <= pf;
    do @(posedge clk); while (busy);
    sb.note_item(fn, pf);
  endtask

  // Frames are drawn from the whole 40-bit space, from large-page aligned values,
  // from just below the top of the space (so that carving wraps) and from small
  // values, so that every bit of the field is seen at both levels.
  function automatic frame_t random_frame();
    frame_t f;
    f = frame_t'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: random_frame = f;
      1: random_frame = f & ~frame_t'(SMALL_PER_LARGE - 1);
      2: random_frame = {{(OUT_FRAME_W - 10){1'b1}}, f[9:0]};
      default: random_frame = frame_t'(f[11:0]);
    endcase
  endfunction

  // Pushes onto one pool until it holds its full depth, and then a few more frees
  // that the block must drop with the pool-full status.
  task automatic fill_pool(pool_id_t p);
    func_t fn;
    case (p)
      POOL_SMALL_DIRTY: fn = FUNC_FREE_SMALL;
      POOL_SMALL_CLEAN: fn = FUNC_FREE_SMALL_CLEAN;
      POOL_LARGE_DIRTY: fn = FUNC_FREE_LARGE;
      default:          fn = FUNC_FREE_LARGE_CLEAN;
    endcase
    while (sb.pool_top[p] < POOL_DEPTH) send_item(fn, random_frame());
    repeat ($urandom_range(1, 3)) send_item(fn, random_frame());
  endtask

  initial begin
    int  kind;
    int  len;
    int  waited;
    bit  pool_filled;
    func_t fn;

    sb           = new();
    quiet_sender = 1'b0;
    pool_filled  = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Every pool starts empty, so all four allocation kinds
    // must answer out of memory first.
    send_item(FUNC_ALLOC_SMALL, '0);
    send_item(FUNC_ALLOC_SMALL_CLEAN, '0);
    send_item(FUNC_ALLOC_LARGE, '0);
    send_item(FUNC_ALLOC_LARGE_CLEAN, '0);
    // A large dirty page near the top of the frame space is split by a small
    // request; the carved frames that follow wrap round past the top.
    send_item(FUNC_FREE_LARGE, 40'hFF_FFFF_FF00);
    send_item(FUNC_ALLOC_SMALL, '0);
    send_item(FUNC_ALLOC_SMALL, '0);
    // A clean small request with nothing clean falls back to the dirty carve.
    send_item(FUNC_ALLOC_SMALL_CLEAN, '0);
    send_item(FUNC_FREE_LARGE_CLEAN, '0);
    send_item(FUNC_ALLOC_LARGE_CLEAN, '0);
    // A clean large request served from the dirty pool must ask for a clear.
    send_item(FUNC_FREE_LARGE, 40'hAA_AAAA_AA00);
    send_item(FUNC_ALLOC_LARGE_CLEAN, '0);
    send_item(FUNC_FREE_SMALL, 40'hFF_FFFF_FFFF);
    send_item(FUNC_FREE_SMALL_CLEAN, '0);
    send_item(FUNC_FREE_SMALL_CLEAN, 40'h55_5555_5555);
    send_item(FUNC_ALLOC_SMALL, '0);
    send_item(FUNC_ALLOC_SMALL_CLEAN, '0);
    send_item(FUNC_ALLOC_SMALL, '0);
    send_item(FUNC_ALLOC_SMALL_CLEAN, '0);
    // A plain large request with the dirty pool empty takes a clean page.
    send_item(FUNC_FREE_LARGE_CLEAN, 40'h12_3456_7800);
    send_item(FUNC_ALLOC_LARGE, '0);
    send_item(FUNC_FREE_LARGE, 40'hFF_FFFF_FE00);
    send_item(FUNC_ALLOC_LARGE, '0);

    // Random part, built from short episodes. Free bursts build the pools up and
    // allocation drains run them down through every fallback, splitting large
    // pages once the small pools are dry. One pool is filled past its depth early
    // enough in the run that the fill fits within the item budget.
    while (sb.item_count < TOTAL_ITEMS) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      kind         = $urandom_range(0, 9);
      if (!pool_filled && (kind == 9 || sb.item_count > 300)) begin
        fill_pool(pool_id_t'($urandom_range(0, 3)));
        pool_filled = 1'b1;
      end else if (kind >= 7) begin
        fn  = func_t'($urandom_range(0, 3));
        len = $urandom_range(1, 60);
        repeat (len) send_item(fn, random_frame());
      end else if (kind >= 5) begin
        fn  = func_t'($urandom_range(4, 7));
        len = $urandom_range(1, 40);
        repeat (len) send_item(fn, random_frame());
      end else begin
        len = $urandom_range(4, 40);
        repeat (len) begin
          if ($urandom_range(0, 1) == 0) fn = func_t'($urandom_range(4, 7));
          else                           fn = func_t'($urandom_range(0, 3));
          send_item(fn, random_frame());
        end
      end
    end
    start <= 1'b0;

    // Every item yields exactly one result, so once nothing is outstanding the run idles
    // before finishing, to show that no stray strobe follows.
    waited = 0;
    while (sb.expected_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_results.size() > 0) begin
      $display("[%0t] %0d results never arrived", $time, sb.expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      repeat (8) @(posedge clk);
      $display("Run covered %0d items, with %0d out-of-memory answers and %0d frees dropped",
               sb.item_count, sb.oom_count, sb.full_count);
      $display("on a full pool, %0d large-page splits and %0d allocations needing a clear.",
               sb.split_count, sb.clear_count);
      if (sb.error_count == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

  // Guard against a hung handshake: far longer than the slowest legal run needs.
  initial begin
    #5_000_000;
    $display("[%0t] run did not complete in time", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
